/* rtl/b62_pkg.sv */
// Shared types, widths and character mapping for the base-62 identifier codec.
package b62_pkg;

    localparam int unsigned NumChars   = 8;
    localparam int unsigned DigitW     = 6;
    localparam int unsigned PackedW    = 48;
    localparam int unsigned CharInW    = 8;
    localparam int unsigned CharOutW   = 7;
    localparam int unsigned InDataW    = 112;
    localparam int unsigned OutDataW   = 112;
    localparam int unsigned NumDigits  = 62;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic               bad;
        logic [PackedW-1:0] data;
    } job_t;

    function automatic logic [DigitW:0] char_to_digit(input logic [CharInW-1:0] c);
        logic [CharInW-1:0] d;
        logic               bad;
        d   = '0;
        bad = 1'b0;
        priority if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h3D;
        end else begin
            bad = 1'b1;
        end
        return {bad, d[DigitW-1:0]};
    endfunction

    function automatic logic [CharOutW-1:0] digit_to_char(input logic [DigitW-1:0] d);
        logic [CharOutW-1:0] c;
        priority if (d < 6'd10) begin
            c = 7'h30 + {1'b0, d};
        end else if (d < 6'd36) begin
            c = 7'h37 + {1'b0, d};
        end else if (d < 6'd62) begin
            c = 7'h3D + {1'b0, d};
        end else begin
            c = '0;
        end
        return c;
    endfunction

endpackage

/* rtl/b62_front.sv */
// Input side: splits the stream item and maps characters to base-62 digits.
module b62_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [b62_pkg::InDataW-1:0]   s_tdata,
    input  logic                          s_tuser,
    output logic                          push_valid,
    input  logic                          push_ready,
    output b62_pkg::job_t                 push_job
);

    logic [b62_pkg::PackedW-1:0] digits;
    logic                        any_bad;
    logic [b62_pkg::DigitW:0]    mapped;

    always_comb begin
        digits  = '0;
        any_bad = 1'b0;
        mapped  = '0;
        for (int k = 0; k < b62_pkg::NumChars; k++) begin
            mapped = b62_pkg::char_to_digit(
                s_tdata[b62_pkg::PackedW + b62_pkg::CharInW*k +: b62_pkg::CharInW]);
            digits[b62_pkg::PackedW - b62_pkg::DigitW*(k+1) +: b62_pkg::DigitW] =
                mapped[b62_pkg::DigitW-1:0];
            any_bad = any_bad | mapped[b62_pkg::DigitW];
        end
    end

    always_comb begin
        push_job.mode = b62_pkg::mode_t'(s_tuser);
        if (push_job.mode == b62_pkg::MODE_ENCODE) begin
            push_job.bad  = any_bad;
            push_job.data = digits;
        end else begin
            push_job.bad  = 1'b0;
            push_job.data = s_tdata[b62_pkg::PackedW-1:0];
        end
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

/* rtl/b62_queue.sv */
// Two-entry queue between the front and the conversion pipeline.
module b62_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  b62_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output b62_pkg::job_t pop_job
);

    b62_pkg::job_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/b62_back.sv */
// Conversion pipeline: eight stages of six bits each, then the output register.
module b62_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  b62_pkg::job_t                pop_job,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [b62_pkg::OutDataW-1:0] m_tdata
);

    localparam int unsigned NumStages = b62_pkg::NumChars;

    typedef struct packed {
        b62_pkg::mode_t              mode;
        logic                        bad;
        logic [b62_pkg::PackedW-1:0] work;
        logic [b62_pkg::PackedW-1:0] acc;
    } stage_t;

    function automatic stage_t conv_step(input stage_t cur);
        stage_t                     nxt;
        logic [b62_pkg::DigitW-1:0] chunk;
        logic [b62_pkg::DigitW-1:0] dig;
        logic                       cin;
        logic                       cout;
        nxt      = cur;
        chunk    = cur.work[b62_pkg::PackedW-1 -: b62_pkg::DigitW];
        nxt.work = {cur.work[b62_pkg::PackedW-b62_pkg::DigitW-1:0], {b62_pkg::DigitW{1'b0}}};
        if (cur.mode == b62_pkg::MODE_ENCODE) begin
            nxt.acc = (cur.acc << 6) - (cur.acc << 1)
                    + {{(b62_pkg::PackedW-b62_pkg::DigitW){1'b0}}, chunk};
        end else begin
            for (int b = b62_pkg::DigitW - 1; b >= 0; b--) begin
                cin = chunk[b];
                for (int i = 0; i < b62_pkg::NumChars; i++) begin
                    dig  = nxt.acc[b62_pkg::DigitW*i +: b62_pkg::DigitW];
                    cout = (dig >= 6'd31);
                    nxt.acc[b62_pkg::DigitW*i +: b62_pkg::DigitW] =
                        cout ? ({dig[4:0], cin} + 6'd2) : {dig[4:0], cin};
                    cin  = cout;
                end
            end
        end
        return nxt;
    endfunction

    stage_t                        stage_reg [NumStages];
    logic   [NumStages-1:0]        valid_reg;
    logic   [NumStages:0]          can_load;
    logic                          out_valid_reg;
    logic   [b62_pkg::OutDataW-1:0] out_data_reg, out_data_next;
    stage_t                        entry;

    always_comb begin
        can_load[NumStages] = !out_valid_reg || m_tready;
        for (int s = NumStages - 1; s >= 0; s--) begin
            can_load[s] = !valid_reg[s] || can_load[s+1];
        end
    end

    assign pop_ready = can_load[0];

    always_comb begin
        entry.mode = pop_job.mode;
        entry.bad  = pop_job.bad;
        entry.work = pop_job.data;
        entry.acc  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (can_load[0]) begin
                valid_reg[0] <= pop_valid;
            end
            for (int s = 1; s < NumStages; s++) begin
                if (can_load[s]) begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (can_load[0]) begin
            stage_reg[0] <= conv_step(entry);
        end
        for (int s = 1; s < NumStages; s++) begin
            if (can_load[s]) begin
                stage_reg[s] <= conv_step(stage_reg[s-1]);
            end
        end
    end

    always_comb begin
        out_data_next = '0;
        if (stage_reg[NumStages-1].mode == b62_pkg::MODE_ENCODE) begin
            out_data_next[b62_pkg::PackedW-1:0] = stage_reg[NumStages-1].acc;
            out_data_next[b62_pkg::PackedW + b62_pkg::CharOutW*b62_pkg::NumChars] =
                stage_reg[NumStages-1].bad;
        end else begin
            for (int k = 0; k < b62_pkg::NumChars; k++) begin
                out_data_next[b62_pkg::PackedW + b62_pkg::CharOutW*k +: b62_pkg::CharOutW] =
                    b62_pkg::digit_to_char(stage_reg[NumStages-1].acc[
                        b62_pkg::DigitW*(b62_pkg::NumChars-1-k) +: b62_pkg::DigitW]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (can_load[NumStages]) begin
            out_valid_reg <= valid_reg[NumStages-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (can_load[NumStages]) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* rtl/base62_id_codec.sv */
// Top level of the base-62 identifier codec: front, queue and conversion pipeline.
//
//  Channel | Direction | Payload
//  s_      | in        | tdata: packed_in, char_in_0..7; tuser: mode
//  m_      | out       | tdata: packed_out, char_out_0..7, bad_char
//
// One item per cycle sustained while the output is not stalled.
// The conversion pipeline has eight stages, six input bits a stage.
// Reset clears the queue count, the stage valid bits and the output valid.
// A stalled output holds the pipeline stage by stage; the two-entry queue
// keeps taking items until it fills.
module base62_id_codec (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [47:0] packed_in, [55:48] char_in_0 ... [111:104] char_in_7
    input  logic [b62_pkg::InDataW-1:0]  s_tdata,
    // [0] mode
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [47:0] packed_out, [54:48] char_out_0 ... [103:97] char_out_7,
    // [104] bad_char, [111:105] zero
    output logic [b62_pkg::OutDataW-1:0] m_tdata
);

    logic          push_valid, push_ready;
    b62_pkg::job_t push_job;
    logic          pop_valid, pop_ready;
    b62_pkg::job_t pop_job;

    b62_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    b62_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    b62_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* rtl/b62_checker.sv */
// Port-level checks for the base-62 identifier codec, bound to the top level.
module b62_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [b62_pkg::InDataW-1:0]  s_tdata,
    input logic                         s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [b62_pkg::OutDataW-1:0] m_tdata
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    a_one_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[103:48] == 56'd0)
                  || (m_tdata[47:0] == 48'd0 && !m_tdata[104]))
        else $error("output item mixes encode and decode fields");

    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[47:0] < 48'd218340105584896)
        else $error("packed value out of base-62 range");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[111:105] == 7'd0)
        else $error("padding bits set");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind base62_id_codec b62_checker u_b62_checker (.*);
